// ===== rtl/wbt_pkg.sv =====
// ----------------------------------------------------------------------------
// wbt_pkg
// shared types, constants and helpers for the wall bounce trajectory block
// ----------------------------------------------------------------------------
package wbt_pkg;

    // internal signed coordinate width, covers point plus clamped quotient
    localparam int CW     = 19;
    // multiplier operand and product widths
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    // divider widths
    localparam int NUM_W  = 36;
    localparam int DEN_W  = 17;
    localparam int QUO_W  = 17;
    localparam int DCNT_W = 5;

    localparam logic [9:0] RADIUS_RESET = 10'd175;

    // register word index of ball_radius
    localparam logic REG_BALL_RADIUS = 1'b0;

    // saturation limits of the coordinate fields
    localparam logic signed [CW-1:0] X_LO = 19'sd0;
    localparam logic signed [CW-1:0] X_HI = 19'sd16383;
    localparam logic signed [CW-1:0] Y_LO = -19'sd8192;
    localparam logic signed [CW-1:0] Y_HI = 19'sd8191;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_END,
        ST_DIV_END,
        ST_WAIT_END,
        ST_CHECK,
        ST_MUL_SIDE,
        ST_DIV_SIDE,
        ST_WAIT_SIDE,
        ST_STORE,
        ST_BAD
    } wbt_state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_start;
        logic side;
        logic take_ey;
        logic check;
        logic take_ex;
        logic store;
        logic store_bad;
        logic cap;
    } wbt_cmd_t;

    typedef struct packed {
        logic dirx_zero;
        logic div_done;
        logic hit;
        logic fin;
        logic out_free;
    } wbt_stat_t;

    function automatic logic [13:0] sat_x(input logic signed [CW-1:0] v);
        logic [13:0] res;
        if (v < X_LO)
            res = X_LO[13:0];
        else if (v > X_HI)
            res = X_HI[13:0];
        else
            res = v[13:0];
        return res;
    endfunction

    function automatic logic signed [13:0] sat_y(input logic signed [CW-1:0] v);
        logic signed [13:0] res;
        if (v < Y_LO)
            res = Y_LO[13:0];
        else if (v > Y_HI)
            res = Y_HI[13:0];
        else
            res = v[13:0];
        return res;
    endfunction

endpackage

// ===== rtl/wall_bounce_trajectory.sv =====
// ----------------------------------------------------------------------------
// wall_bounce_trajectory
// ball path in a rectangular field, one straight segment per result
//
//   channel  direction  handshake          payload
//   config   in         psel/penable/...   ball_radius at word 0 (APB style)
//   in       in         in_valid/ready     pos_x, pos_y, dir_x, dir_y
//   out      out        out_valid/ready    seg_start_*, seg_end_*, last,
//                                          bad_direction
//
// a request yields at most MAX_SEGMENTS segments; the serial divider
// makes 17 quotient bits, one per cycle, once per end wall test and once
// more per side wall contact
// reset clears control only; ball_radius comes back as 175
// a stalled out channel holds one result in the output register while the
// next segment is computed; the sequencer waits only to store the one after
// ----------------------------------------------------------------------------
module wall_bounce_trajectory
    import wbt_pkg::*;
#(
    parameter int FIELD_LENGTH     = 12100,
    parameter int FIELD_HALF_WIDTH = 3515,
    parameter int MAX_SEGMENTS     = 10
)
(
    input  logic               clk,
    input  logic               rst_n,

    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    // ball state request
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [13:0]        pos_x,
    input  logic signed [13:0] pos_y,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,

    // segment results
    output logic               out_valid,
    input  logic               out_ready,
    output logic [13:0]        seg_start_x,
    output logic signed [13:0] seg_start_y,
    output logic [13:0]        seg_end_x,
    output logic signed [13:0] seg_end_y,
    output logic               last,
    output logic               bad_direction
);

    logic [9:0] radius_reg, radius_next;
    logic       cfg_wr;
    wbt_cmd_t   cmd;
    wbt_stat_t  stat;

    // register write on the access phase; word index from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        radius_next = radius_reg;
        if (cfg_wr && (paddr[2] == REG_BALL_RADIUS))
            radius_next = pwdata[9:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else
            radius_reg <= radius_next;
    end

    // read back; words beyond the register list read zero
    always_comb
    begin
        unique case (paddr[2])
            REG_BALL_RADIUS: prdata = {22'd0, radius_reg};
            default:         prdata = '0;
        endcase
    end

    // sequencer
    wbt_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and result register
    wbt_datapath #(
        .FIELD_LENGTH     (FIELD_LENGTH),
        .FIELD_HALF_WIDTH (FIELD_HALF_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .radius        (radius_reg),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .seg_start_x   (seg_start_x),
        .seg_start_y   (seg_start_y),
        .seg_end_x     (seg_end_x),
        .seg_end_y     (seg_end_y),
        .last          (last),
        .bad_direction (bad_direction)
    );

    // the segment at the cap always closes the run
    a_cap_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.store && cmd.cap) |-> stat.fin)
        else $error("segment cap reached without ending the run");

    // a flagged direction is always a single, final result
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_direction) |-> last)
        else $error("bad direction result not marked last");

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new request taken while one is in progress");

endmodule

// ===== rtl/wbt_div.sv =====
// ----------------------------------------------------------------------------
// wbt_div
// serial restoring divider, one quotient bit per cycle, clamps on overflow
// ----------------------------------------------------------------------------
module wbt_div
    import wbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic               done,
    output logic [QUO_W-1:0]   quo
);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [QUO_W-1:0]  q_reg, q_next;
    logic              ovf_reg, ovf_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = NUM_W'({den, {(QUO_W-1){1'b0}}});
            // quotient would not fit: result saturates
            ovf_next  = (num >= NUM_W'({den, {QUO_W{1'b0}}}));
            q_next    = '0;
            cnt_next  = DCNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_next = rem_reg - dsh_reg;
            q_next   = {q_reg[QUO_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quo  = ovf_reg ? {QUO_W{1'b1}} : q_reg;

    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##18 done_reg)
        else $error("divider result not ready after fixed latency");

    a_div_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

// ===== rtl/wbt_datapath.sv =====
// ----------------------------------------------------------------------------
// wbt_datapath
// point and direction registers, multiplier, divider and result register
// ----------------------------------------------------------------------------
module wbt_datapath
    import wbt_pkg::*;
#(
    parameter int FIELD_LENGTH     = 12100,
    parameter int FIELD_HALF_WIDTH = 3515
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [9:0]         radius,
    input  logic [13:0]        pos_x,
    input  logic signed [13:0] pos_y,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  wbt_cmd_t           cmd,
    output wbt_stat_t          stat,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [13:0]        seg_start_x,
    output logic signed [13:0] seg_start_y,
    output logic [13:0]        seg_end_x,
    output logic signed [13:0] seg_end_y,
    output logic               last,
    output logic               bad_direction
);

    logic [13:0]               cx_reg;
    logic signed [13:0]        cy_reg;
    logic signed [MUL_W-1:0]   dx_reg, dy_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      neg_reg;
    logic signed [CW-1:0]      ey_raw_reg, ex_raw_reg;
    logic                      hit_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [13:0]               sx_reg, ex_reg;
    logic signed [13:0]        sy_reg, ey_reg;
    logic                      last_reg, bad_reg;

    logic signed [CW-1:0]      r_s, xlo, xhi, ylo, yhi, tx, yw, cx_s, cy_s;
    logic signed [CW-1:0]      diff;
    logic signed [MUL_W-1:0]   op_a, op_b, div_d, abs_d;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]         abs_p;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic                      div_done;
    logic [QUO_W-1:0]          div_quo;
    logic signed [CW-1:0]      q_s, q_signed;
    logic                      hit_now;
    logic [13:0]               ex_pt;
    logic signed [13:0]        ey_pt;
    logic                      fin;

    // inset walls
    assign r_s  = signed'(CW'(radius));
    assign xlo  = r_s;
    assign xhi  = CW'(FIELD_LENGTH) - r_s;
    assign yhi  = CW'(FIELD_HALF_WIDTH) - r_s;
    assign ylo  = r_s - CW'(FIELD_HALF_WIDTH);
    assign tx   = dx_reg[MUL_W-1] ? xlo : xhi;
    assign yw   = dy_reg[MUL_W-1] ? ylo : yhi;
    assign cx_s = signed'(CW'(cx_reg));
    assign cy_s = CW'(cy_reg);

    // distance to the wall fits the multiplier operand
    assign diff = cmd.side ? (yw - cy_s) : (tx - cx_s);
    assign op_a = diff[MUL_W-1:0];
    assign op_b = cmd.side ? dx_reg : dy_reg;
    assign prod = op_a * op_b;

    // rounded division: (2|n| + |d|) / (2|d|)
    assign div_d   = cmd.side ? dy_reg : dx_reg;
    assign abs_d   = div_d[MUL_W-1] ? -div_d : div_d;
    assign abs_p   = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign div_num = NUM_W'({abs_p, 1'b0}) + NUM_W'(abs_d[MUL_W-2:0]);
    assign div_den = {abs_d[MUL_W-2:0], 1'b0};

    wbt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign q_s      = signed'(CW'(div_quo));
    assign q_signed = neg_reg ? -q_s : q_s;

    assign hit_now = (!dy_reg[MUL_W-1] && (dy_reg != '0) && (ey_raw_reg > yhi)) ||
                     (dy_reg[MUL_W-1] && (ey_raw_reg < ylo));

    // segment end point and run end
    assign ex_pt = hit_reg ? sat_x(ex_raw_reg) : sat_x(tx);
    assign ey_pt = hit_reg ? sat_y(yw) : sat_y(ey_raw_reg);
    assign fin   = !hit_reg || (signed'(CW'(ex_pt)) == tx) || cmd.cap;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cx_reg <= pos_x;
            cy_reg <= pos_y;
            dx_reg <= MUL_W'(dir_x);
            dy_reg <= MUL_W'(dir_y);
        end
        else if (cmd.store)
        begin
            cx_reg <= ex_pt;
            cy_reg <= ey_pt;
            if (hit_reg)
                dy_reg <= -dy_reg;
            else
                dx_reg <= -dx_reg;
        end
        if (cmd.mul)
            prod_reg <= prod;
        if (cmd.div_start)
            neg_reg <= prod_reg[PROD_W-1] ^ div_d[MUL_W-1];
        if (cmd.take_ey)
            ey_raw_reg <= cy_s + q_signed;
        if (cmd.take_ex)
            ex_raw_reg <= cx_s + q_signed;
        if (cmd.check)
            hit_reg <= hit_now;
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.store || cmd.store_bad)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            sx_reg   <= cx_reg;
            sy_reg   <= cy_reg;
            ex_reg   <= ex_pt;
            ey_reg   <= ey_pt;
            last_reg <= fin;
            bad_reg  <= 1'b0;
        end
        else if (cmd.store_bad)
        begin
            sx_reg   <= cx_reg;
            sy_reg   <= cy_reg;
            ex_reg   <= cx_reg;
            ey_reg   <= cy_reg;
            last_reg <= 1'b1;
            bad_reg  <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign seg_start_x   = sx_reg;
    assign seg_start_y   = sy_reg;
    assign seg_end_x     = ex_reg;
    assign seg_end_y     = ey_reg;
    assign last          = last_reg;
    assign bad_direction = bad_reg;

    assign stat.dirx_zero = (dir_x == '0);
    assign stat.div_done  = div_done;
    assign stat.hit       = hit_now;
    assign stat.fin       = fin;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

// ===== rtl/wbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// wbt_ctrl
// sequencer for one request: segment loop, divider handoff, result stores
// ----------------------------------------------------------------------------
module wbt_ctrl
    import wbt_pkg::*;
#(
    parameter int MAX_SEGMENTS = 10
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  wbt_stat_t stat,
    output wbt_cmd_t  cmd
);

    localparam int CNT_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    wbt_state_t       state_reg, state_next;
    logic [CNT_W-1:0] seg_cnt_reg, seg_cnt_next;
    logic             cap;

    assign cap = (seg_cnt_reg == CNT_W'(MAX_SEGMENTS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = stat.dirx_zero ? ST_BAD : ST_MUL_END;
            ST_MUL_END:  state_next = ST_DIV_END;
            ST_DIV_END:  state_next = ST_WAIT_END;
            ST_WAIT_END:
                if (stat.div_done)
                    state_next = ST_CHECK;
            ST_CHECK:    state_next = stat.hit ? ST_MUL_SIDE : ST_STORE;
            ST_MUL_SIDE: state_next = ST_DIV_SIDE;
            ST_DIV_SIDE: state_next = ST_WAIT_SIDE;
            ST_WAIT_SIDE:
                if (stat.div_done)
                    state_next = ST_STORE;
            ST_STORE:
                if (stat.out_free)
                    state_next = stat.fin ? ST_IDLE : ST_MUL_END;
            ST_BAD:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.cap  = cap;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_MUL_END:  cmd.mul = 1'b1;
            ST_DIV_END:  cmd.div_start = 1'b1;
            ST_WAIT_END: cmd.take_ey = stat.div_done;
            ST_CHECK:    cmd.check = 1'b1;
            ST_MUL_SIDE:
            begin
                cmd.mul  = 1'b1;
                cmd.side = 1'b1;
            end
            ST_DIV_SIDE:
            begin
                cmd.div_start = 1'b1;
                cmd.side      = 1'b1;
            end
            ST_WAIT_SIDE: cmd.take_ex = stat.div_done;
            ST_STORE:     cmd.store = stat.out_free;
            ST_BAD:       cmd.store_bad = stat.out_free;
            default:      cmd = '0;
        endcase
    end

    always_comb
    begin
        seg_cnt_next = seg_cnt_reg;
        if (cmd.load_in)
            seg_cnt_next = '0;
        else if (cmd.store)
            seg_cnt_next = seg_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seg_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            seg_cnt_reg <= seg_cnt_next;
        end
    end

endmodule

// ===== tb/wall_bounce_trajectory_tb.sv =====
// ----------------------------------------------------------------------------
// wall_bounce_trajectory_tb
// self-checking bench for the ball path reflection block
//
// queued ball states go out through a clocked driver, each accepted request
// is traced by a local path model, and a clocked monitor under random
// back-pressure compares segments field by field; the ball radius register
// is rewritten and read back between phases, both extremes included
// ----------------------------------------------------------------------------
module wall_bounce_trajectory_tb
    import wbt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_LENGTH     = 12100;
    localparam int FIELD_HALF_WIDTH = 3515;
    localparam int MAX_SEGMENTS     = 10;

    // byte address of the radius register, one 32-bit word per register
    localparam logic [2:0] ADDR_BALL_RADIUS = 3'(4 * REG_BALL_RADIUS);

    // idle cycles after the last segment
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [13:0] px;
        logic [13:0] py;
        logic [15:0] dx;
        logic [15:0] dy;
    } ball_t;

    typedef struct packed {
        logic [13:0] sx;
        logic [13:0] sy;
        logic [13:0] ex;
        logic [13:0] ey;
        logic        fin;
        logic        bad;
    } segment_t;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [13:0]        pos_x = '0;
    logic signed [13:0] pos_y = '0;
    logic signed [15:0] dir_x = '0;
    logic signed [15:0] dir_y = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [13:0]        seg_start_x;
    logic signed [13:0] seg_start_y;
    logic [13:0]        seg_end_x;
    logic signed [13:0] seg_end_y;
    logic               last;
    logic               bad_direction;

    always #2 clk = ~clk;

    wall_bounce_trajectory #(
        .FIELD_LENGTH     (FIELD_LENGTH),
        .FIELD_HALF_WIDTH (FIELD_HALF_WIDTH),
        .MAX_SEGMENTS     (MAX_SEGMENTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .seg_start_x   (seg_start_x),
        .seg_start_y   (seg_start_y),
        .seg_end_x     (seg_end_x),
        .seg_end_y     (seg_end_y),
        .last          (last),
        .bad_direction (bad_direction)
    );

    // ------------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------------
    ball_t    pending_balls[$];
    segment_t expected_segs[$];
    logic [9:0] radius_now = 10'd175;    // mirror of the register, reset value
    int send_idle_pct = 9;
    int recv_idle_pct = 75;
    int error_count   = 0;

    // ------------------------------------------------------------------------
    // path model
    // ------------------------------------------------------------------------

    // quotient rounded to nearest, ties away from zero
    function automatic longint round_div(input longint num, input longint den);
        longint a;
        longint b;
        longint q;
        a = (num < 0) ? -num : num;
        b = (den < 0) ? -den : den;
        q = (2 * a + b) / (2 * b);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // walk one ball state through the field and queue every segment it makes
    function automatic void trace_path(input ball_t b, input logic [9:0] rad);
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint x_lo;
        longint x_hi;
        longint y_lo;
        longint y_hi;
        longint tx;
        longint ex;
        longint ey;
        logic   fin;
        int     n;
        segment_t s;

        cx   = longint'(b.px);
        cy   = longint'($signed(b.py));
        dx   = longint'($signed(b.dx));
        dy   = longint'($signed(b.dy));
        x_lo = longint'(rad);
        x_hi = FIELD_LENGTH - longint'(rad);
        y_lo = -FIELD_HALF_WIDTH + longint'(rad);
        y_hi = FIELD_HALF_WIDTH - longint'(rad);

        // no horizontal motion: one flagged segment at the input point
        if (dx == 0)
        begin
            s = '{sx: b.px, sy: b.py, ex: b.px, ey: b.py, fin: 1'b1, bad: 1'b1};
            expected_segs = {expected_segs, s};
            return;
        end

        for (n = 0; n < MAX_SEGMENTS; n++)
        begin
            tx  = (dx > 0) ? x_hi : x_lo;
            ex  = tx;
            fin = 1'b1;
            ey  = cy + round_div((tx - cx) * dy, dx);
            // a side wall counts only when the end wall Y lies strictly beyond it
            if (dy > 0 && ey > y_hi)
            begin
                ex  = cx + round_div((y_hi - cy) * dx, dy);
                ey  = y_hi;
                dy  = -dy;
                fin = 1'b0;
            end
            else if (dy < 0 && ey < y_lo)
            begin
                ex  = cx + round_div((y_lo - cy) * dx, dy);
                ey  = y_lo;
                dy  = -dy;
                fin = 1'b0;
            end
            else
            begin
                dx = -dx;
            end
            ex = clamp(ex, 0, 16383);
            ey = clamp(ey, -8192, 8191);
            // a side contact that rounds onto the end wall is a corner
            if (ex == tx)
                fin = 1'b1;
            if (n + 1 >= MAX_SEGMENTS)
                fin = 1'b1;
            s = '{sx: 14'(cx), sy: 14'(cy), ex: 14'(ex), ey: 14'(ey), fin: fin, bad: 1'b0};
            expected_segs = {expected_segs, s};
            cx = ex;
            cy = ey;
            if (fin)
                break;
        end
    endfunction

    // ------------------------------------------------------------------------
    // request driver: presents queued ball states, traces each accepted one
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : request_driver
        ball_t nxt;
        logic  taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            taken = in_valid && in_ready;
            if (taken)
                trace_path(ball_t'{px: pos_x, py: pos_y, dx: dir_x, dy: dir_y}, radius_now);
            // a held request keeps its payload until it is accepted
            if (!in_valid || taken)
            begin
                if (pending_balls.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_balls.pop_front();
                    in_valid <= 1'b1;
                    pos_x    <= nxt.px;
                    pos_y    <= nxt.py;
                    dir_x    <= nxt.dx;
                    dir_y    <= nxt.dy;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // segment monitor: random back-pressure, in-order field compare
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : segment_monitor
        segment_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_segs.size() == 0)
                begin
                    $error("segment with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = expected_segs.pop_front();
                    check_field("seg_start_x", want.sx, seg_start_x);
                    check_field("seg_start_y", $signed(want.sy), seg_start_y);
                    check_field("seg_end_x", want.ex, seg_end_x);
                    check_field("seg_end_y", $signed(want.ey), seg_end_y);
                    check_field("last", want.fin, last);
                    check_field("bad_direction", want.bad, bad_direction);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // configuration access
    // ------------------------------------------------------------------------
    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_BALL_RADIUS;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        // read data is sampled mid access cycle, away from the edges
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // only called with the block idle, so the mirror can move right away
    task automatic set_radius(input logic [9:0] val);
        logic [31:0] rd;
        apb_xfer(1'b1, {22'd0, val}, rd);
        radius_now = val;
        apb_xfer(1'b0, '0, rd);
        if (rd !== {22'd0, val})
        begin
            $error("ball_radius readback: expected %0d, got %0d", val, rd);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int rand_signed(input int lo, input int hi);
        int v;
        v = $urandom_range(hi, lo);
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic queue_ball(input int px, input int py, input int dx, input int dy);
        ball_t b;
        b = '{px: 14'(px), py: 14'(py), dx: 16'(dx), dy: 16'(dy)};
        pending_balls = {pending_balls, b};
    endtask

    // mostly well-formed balls inside the inset field, plus the odd cases
    task automatic queue_random(input int count);
        int i;
        int sel;
        int r;
        for (i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            r   = int'(radius_now);
            if (sel < 60)
            begin
                queue_ball($urandom_range(FIELD_LENGTH - r, r),
                           int'($urandom_range(2 * (FIELD_HALF_WIDTH - r))) - FIELD_HALF_WIDTH + r,
                           rand_signed(1, 16384), rand_signed(0, 16384));
            end
            else if (sel < 72)
            begin
                // shallow X travel, steep Y: long bounce chains up to the cap
                queue_ball($urandom_range(FIELD_LENGTH - r, r),
                           int'($urandom_range(2 * (FIELD_HALF_WIDTH - r))) - FIELD_HALF_WIDTH + r,
                           rand_signed(1, 800), rand_signed(8000, 16384));
            end
            else if (sel < 80)
            begin
                queue_ball($urandom, $urandom, 0, $urandom);
            end
            else if (sel < 86)
            begin
                queue_ball($urandom_range(16383), $urandom, rand_signed(1, 16384), 0);
            end
            else
            begin
                // raw bit patterns: outside points, non-unit directions
                queue_ball($urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    // sender pauses here until the block has delivered everything
    task automatic wait_drained();
        while (pending_balls.size() != 0 || in_valid || expected_segs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed set at the reset radius, inset walls x 175..11925, y +-3340
        queue_ball(6000, 0, 0, 5000);            // zero X direction
        queue_ball(16383, -8192, 0, 0);          // zero X direction, field extremes
        queue_ball(6050, 0, 16384, 0);           // zero Y direction, right wall
        queue_ball(6050, 0, -16384, 0);          // zero Y direction, left wall
        queue_ball(6050, 0, 11585, 11585);       // diagonal, top wall first
        queue_ball(6050, 0, -11585, -11585);     // diagonal, bottom wall first
        queue_ball(11924, 3339, 8192, 16384);    // side contact rounds into corner
        queue_ball(6050, 0, 200, 16383);         // bounce chain hits segment cap
        queue_ball(6050, 0, -200, -16384);       // cap going the other way
        queue_ball(0, 8191, 16384, 16384);       // start beyond top, contact clamps
        queue_ball(16383, 8191, -16384, 16384);  // contact X clamps high
        queue_ball(16383, -8192, -32768, -32768);// most negative direction
        queue_ball(0, 0, 32767, 32767);          // most positive direction
        queue_ball(100, 100, -1, 1);             // tiny direction
        queue_ball(100, -100, 1, -1);
        queue_ball(0, -8192, 16384, -16384);
        queue_ball(6050, 0, 16384, -32768);
        queue_ball(6050, 3340, -32768, 0);
        queue_ball(11925, -3340, 16384, 16384);  // start on a corner
        queue_ball(175, 3340, -16384, 16384);
        queue_ball(6050, 0, 16384, 16384);
        wait_drained();

        // radius zero: walls at the field edges
        set_radius(10'd0);
        queue_random(100);
        wait_drained();

        // largest radius, sender now the mostly idle side
        send_idle_pct = 75;
        recv_idle_pct = 9;
        set_radius(10'd1023);
        queue_random(30);
        wait_drained();
        queue_random(30);
        wait_drained();

        set_radius(10'($urandom_range(1022, 1)));
        queue_random(100);
        wait_drained();

        // back to the reset radius at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_radius(10'd175);
        queue_random(130);
        wait_drained();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
